>>> design/analog_quadrature_decoder_core_assert.svh
// Assertion macros shared by the decoder core.
`ifndef ANALOG_QUADRATURE_DECODER_CORE_ASSERT_SVH
`define ANALOG_QUADRATURE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define AQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decoder core assertion failed");

// Next-cycle implication, checked while out of reset.
`define AQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decoder core assertion failed");

`endif

>>> design/aqd_pkg.sv
`timescale 1ns / 1ps
package aqd_pkg;

  localparam int COUNT_BITS = 8;
  localparam int LEVEL_BITS = 8;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [LEVEL_BITS-1:0] UPPER_RESET = 8'h00;
  localparam logic [LEVEL_BITS-1:0] LOWER_RESET = 8'hFF;
  localparam logic [LEVEL_BITS-1:0] DECISION_RESET = 8'h80;

  localparam logic [3:0] HIST_INC = 4'hC;
  localparam logic [3:0] HIST_DEC = 4'h3;

  typedef enum logic [1:0] {
    ACT_SAMPLE      = 2'd0,
    ACT_RESET_COUNT = 2'd1,
    ACT_CLEAR_FLAG  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    LED_HOLD  = 2'd0,
    LED_COUNT = 2'd1,
    LED_FLAG  = 2'd2
  } led_mode_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CALIBRATE      = 4'd0,
    CFG_COMPARE_ENABLE = 4'd1,
    CFG_COMPARE_VALUE  = 4'd2,
    CFG_LED_MODE       = 4'd3
  } cfg_index_e;

  typedef struct packed {
    logic                  calibrate;
    logic                  compare_enable;
    logic [LEVEL_BITS-1:0] compare_value;
    logic [1:0]            led_mode;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] upper;
    logic [LEVEL_BITS-1:0] lower;
    logic [LEVEL_BITS-1:0] decision;
    logic                  learning;
    logic [3:0]            history;
    logic                  phase;
    logic [COUNT_BITS-1:0] position;
    logic                  fired;
    logic                  flag;
    logic                  indicator;
  } state_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [LEVEL_BITS-1:0] sample;
  } item_t;

endpackage

>>> design/analog_quadrature_decoder_core.sv
`timescale 1ns / 1ps
// Decoder for an optical quadrature encoder read through an 8-bit converter.
// Requests arrive on the s_axis channel: tuser carries the action (sample,
// reset count, clear compare flag) and tdata the converter reading, which
// alternates between channel B and channel A. Every request yields exactly
// one result on the m_axis channel with the count, the compare flag, the LED
// level, the decision threshold and the learned upper and lower levels, all
// as they stand after that request.
// The cfg channel writes the calibrate, compare enable, compare value and LED
// mode registers; it is always ready and should only be used while no request
// is in flight.
// From acceptance, a request passes through the input register and then the
// result register. Throughput is one request per cycle while the receiver
// keeps up, set by the combinational update of the decoder state between
// those two registers.
// If the receiver stalls, the result register holds its value and the input
// register takes one more request, after which s_axis_tready drops.
// Reset clears both channels, restores the levels to 0 and 255, the threshold
// to 128, and zeroes the count, the flags and the configuration.
module analog_quadrature_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // s_axis_tdata: [7:0] sample
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,
  // s_axis_tuser: [1:0] action
  input  logic [1:0]                         s_axis_tuser,
  // m_axis_tdata: [7:0] count, [8] compare_flag, [9] led, [17:10] threshold,
  // [25:18] level_max, [33:26] level_min, [39:34] zero
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aqd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [aqd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import aqd_pkg::*;

  cfg_t   cfg;
  item_t  in_item, held_item;
  logic   held_valid, advance;
  state_t state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic [39:0] out_data_q;

  aqd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_item.action = s_axis_tuser;
  assign in_item.sample = s_axis_tdata;

  aqd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (advance),
    .item_o  (held_item)
  );

  // A held request moves on whenever the result register is empty or drains.
  assign advance = held_valid && (!out_valid_q || m_axis_tready);

  aqd_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (held_item),
    .state_o (state_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.upper     <= UPPER_RESET;
      state_q.lower     <= LOWER_RESET;
      state_q.decision  <= DECISION_RESET;
      state_q.learning  <= 1'b0;
      state_q.history   <= '0;
      state_q.phase     <= 1'b0;
      state_q.position  <= '0;
      state_q.fired     <= 1'b0;
      state_q.flag      <= 1'b0;
      state_q.indicator <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // The result register carries the state as it stands after the request.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, state_d.lower, state_d.upper, state_d.decision,
                     state_d.indicator, state_d.flag, state_d.position[7:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`include "analog_quadrature_decoder_core_assert.svh"

  // A full input register in front of a stalled result must push back.
  `AQD_ASSERT_NOW(a_backpressure, held_valid && out_valid_q && !m_axis_tready, !s_axis_tready)
  // The compare flag is only ever raised together with the one-shot latch.
  `AQD_ASSERT_NOW(a_flag_fired, state_q.flag, state_q.fired)
  // Every request taken by the datapath shows up as a result next cycle.
  `AQD_ASSERT_NEXT(a_result_follows, advance, m_axis_tvalid)

endmodule

>>> design/aqd_cfg.sv
`timescale 1ns / 1ps
module aqd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aqd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [aqd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output aqd_pkg::cfg_t                      cfg_o
);
  import aqd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_CALIBRATE:      cfg_d.calibrate = cfg_data_i[0];
        CFG_COMPARE_ENABLE: cfg_d.compare_enable = cfg_data_i[0];
        CFG_COMPARE_VALUE:  cfg_d.compare_value = cfg_data_i[LEVEL_BITS-1:0];
        CFG_LED_MODE:       cfg_d.led_mode = cfg_data_i[1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

>>> design/aqd_in_reg.sv
`timescale 1ns / 1ps
module aqd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  aqd_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           take_i,
  output aqd_pkg::item_t item_o
);
  import aqd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The slot frees up in the same cycle that the datapath takes its request.
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end
endmodule

>>> design/aqd_step.sv
`timescale 1ns / 1ps
module aqd_step (
  input  aqd_pkg::cfg_t   cfg_i,
  input  aqd_pkg::state_t state_i,
  input  aqd_pkg::item_t  item_i,
  output aqd_pkg::state_t state_o
);
  import aqd_pkg::*;

  logic [LEVEL_BITS-1:0] up, lo, half;
  logic                  level_bit;
  logic [3:0]            hist;
  state_t                st;

  always_comb begin
    st        = state_i;
    up        = '0;
    lo        = '0;
    half      = '0;
    level_bit = 1'b0;
    hist      = '0;
    case (action_e'(item_i.action))
      ACT_SAMPLE: begin
        if (cfg_i.calibrate) begin
          // A fresh calibration starts from the reset levels, upper 0 and lower 255.
          up = st.learning ? st.upper : UPPER_RESET;
          lo = st.learning ? st.lower : LOWER_RESET;
          if (item_i.sample > up) begin
            up = up + ((item_i.sample - up) >> 1);
          end
          if (item_i.sample < lo) begin
            lo = lo - ((lo - item_i.sample) >> 1);
          end
          st.upper    = up;
          st.lower    = lo;
          st.learning = 1'b1;
        end else if (st.learning) begin
          half        = (st.upper - st.lower) >> 1;
          st.decision = st.lower + half;
          st.learning = 1'b0;
        end else begin
          level_bit = item_i.sample > st.decision;
          if (st.phase) begin
            hist = {st.history[2:0], level_bit ^ st.history[0]};
            if (hist == HIST_INC) begin
              st.position = st.position + COUNT_BITS'(1);
            end else if (hist == HIST_DEC) begin
              st.position = st.position - COUNT_BITS'(1);
            end
          end else begin
            hist = {st.history[2:0], level_bit};
          end
          st.history = hist;
          st.phase   = !st.phase;
        end
      end
      ACT_RESET_COUNT: st.position = '0;
      ACT_CLEAR_FLAG:  st.flag = 1'b0;
      default:         st = state_i;
    endcase

    if (cfg_i.compare_enable && (st.position == COUNT_BITS'(cfg_i.compare_value))
        && !st.fired) begin
      st.flag  = 1'b1;
      st.fired = 1'b1;
    end
    if (!st.flag && st.fired) begin
      st.fired = 1'b0;
    end

    case (led_mode_e'(cfg_i.led_mode))
      LED_COUNT: st.indicator = st.position[0];
      LED_FLAG:  st.indicator = st.flag;
      default:   st.indicator = st.indicator;
    endcase

    state_o = st;
  end
endmodule

>>> sim/aqd_checker.sv
`timescale 1ns / 1ps
// Watches the request, result and register channels of the decoder core. It
// keeps its own copy of the decoder state and checks every result against it.
module aqd_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  input  logic                               s_ready_i,
  input  logic [7:0]                         s_data_i,
  input  logic [1:0]                         s_user_i,
  input  logic                               m_valid_i,
  input  logic                               m_ready_i,
  input  logic [39:0]                        m_data_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [aqd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [aqd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output int unsigned                        outstanding_o,
  output int unsigned                        mismatches_o
);
  import aqd_pkg::*;

  // Result layout, highest field first.
  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] level_min;
    logic [7:0] level_max;
    logic [7:0] threshold;
    logic       led;
    logic       flag;
    logic [7:0] count;
  } reading_t;

  reading_t    expected_readings[$];
  int unsigned errs;

  logic       cal_en, cmp_en;
  logic [7:0] cmp_val;
  logic [1:0] led_sel;
  logic [7:0] upper, lower, decision, position;
  logic [3:0] history;
  logic       learning, a_next, fired, flag, led;

  function automatic reading_t track_decoder(input logic [1:0] act, input logic [7:0] smp);
    reading_t   r;
    logic       level_hi, c;
    logic [7:0] span;
    case (act)
      ACT_SAMPLE: begin
        if (cal_en) begin
          // A fresh calibration forgets the previously learned levels.
          if (!learning) begin
            upper    = UPPER_RESET;
            lower    = LOWER_RESET;
            learning = 1'b1;
          end
          if (smp > upper) upper = upper + ((smp - upper) >> 1);
          if (smp < lower) lower = lower - ((lower - smp) >> 1);
        end else if (learning) begin
          span     = upper - lower;
          decision = lower + (span >> 1);
          learning = 1'b0;
        end else begin
          level_hi = smp > decision;
          if (a_next) begin
            c       = level_hi ^ history[0];
            history = {history[2:0], c};
            if (history == HIST_INC) position = position + 8'd1;
            else if (history == HIST_DEC) position = position - 8'd1;
          end else begin
            history = {history[2:0], level_hi};
          end
          a_next = !a_next;
        end
      end
      ACT_RESET_COUNT: position = '0;
      ACT_CLEAR_FLAG:  flag = 1'b0;
      default: ;
    endcase
    if (cmp_en && position == cmp_val && !fired) begin
      flag  = 1'b1;
      fired = 1'b1;
    end
    if (!flag && fired) fired = 1'b0;
    if (led_sel == LED_COUNT) led = position[0];
    else if (led_sel == LED_FLAG) led = flag;
    r.pad       = '0;
    r.level_min = lower;
    r.level_max = upper;
    r.threshold = decision;
    r.led       = led;
    r.flag      = flag;
    r.count     = position;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    reading_t got, want;
    if (!rst_ni) begin
      cal_en   = 1'b0;
      cmp_en   = 1'b0;
      cmp_val  = '0;
      led_sel  = LED_HOLD;
      upper    = UPPER_RESET;
      lower    = LOWER_RESET;
      decision = DECISION_RESET;
      learning = 1'b0;
      history  = '0;
      a_next   = 1'b0;
      position = '0;
      fired    = 1'b0;
      flag     = 1'b0;
      led      = 1'b0;
      errs     = 0;
      expected_readings.delete();
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CALIBRATE:      cal_en = cfg_data_i[0];
          CFG_COMPARE_ENABLE: cmp_en = cfg_data_i[0];
          CFG_COMPARE_VALUE:  cmp_val = cfg_data_i[7:0];
          CFG_LED_MODE:       led_sel = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) expected_readings.push_back(track_decoder(s_user_i, s_data_i));
      if (m_valid_i && m_ready_i) begin
        got = reading_t'(m_data_i);
        if (expected_readings.size() == 0) begin
          $error("result %h arrived with no request outstanding", m_data_i);
          errs++;
        end else begin
          want = expected_readings.pop_front();
          check_field("count", want.count, got.count);
          check_field("compare_flag", 8'(want.flag), 8'(got.flag));
          check_field("led", 8'(want.led), 8'(got.led));
          check_field("threshold", want.threshold, got.threshold);
          check_field("level_max", want.level_max, got.level_max);
          check_field("level_min", want.level_min, got.level_min);
          check_field("padding", 8'(want.pad), 8'(got.pad));
        end
      end
      outstanding_o <= expected_readings.size();
      mismatches_o  <= errs;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the analog quadrature decoder core. The checker
// beside the block does all the predicting and comparing; this module only
// makes requests, register writes and back-pressure.
module tb_top;
  import aqd_pkg::*;

  // Codes outside the defined sets, which the block must ignore.
  localparam logic [1:0]                ACT_SPARE      = 2'd3;
  localparam logic [1:0]                LED_MODE_SPARE = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED     = 4'hF;

  // The longest legitimate stretch without any handshake is a sender gap plus
  // a receiver stall plus the pipeline.
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_END = 650;
  localparam int unsigned QUIET_FROM = 560;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = ACT_SAMPLE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = CFG_CALIBRATE;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  int unsigned outstanding, mismatches;

  // Idling controls, set by the stimulus as the run goes through its phases.
  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  bit quiet     = 1'b0;

  // A rough shadow of the channel alignment so that encoder steps start on a
  // B sample: calibration samples and the discarded one do not advance it.
  bit          cal_on, learn_due, a_next;
  logic [1:0]  enc_pos;
  int unsigned requests;

  always #5 clk_i = ~clk_i;

  analog_quadrature_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  aqd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  // Receiver back-pressure: bursts of stalls, each followed by a burst of
  // readiness, or plain readiness when stalls are switched off or the run is quiet.
  int unsigned rx_left = 0;
  always @(posedge clk_i) begin
    if (quiet || !rx_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (m_axis_tready && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      rx_left       <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
      rx_left       <= $urandom_range(0, 19);
    end
  end

  // Watchdog: ends the run if no handshake of any kind happens for too long,
  // which also catches results that never arrive.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request, optionally after a random gap, and returns at the
  // edge where it is taken. The valid stays high so that a following request
  // can go straight out; whoever pauses next lowers it.
  task automatic send_request(input logic [1:0] act, input logic [7:0] smp);
    if (tx_gaps && !quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    requests++;
    if (act == ACT_SAMPLE) begin
      if (cal_on) learn_due = 1'b1;
      else if (learn_due) learn_due = 1'b0;
      else a_next = !a_next;
    end
  endtask

  function automatic logic [7:0] level_for(input logic lit);
    return lit ? 8'($urandom_range(170, 255)) : 8'($urandom_range(0, 85));
  endfunction

  // One encoder movement: the B channel sample followed by the A channel
  // sample of the new Gray-coded position. Any pending discard or a stray
  // A slot is used up first so that the pair lines up.
  task automatic step_encoder(input int dir);
    while (a_next || learn_due) send_request(ACT_SAMPLE, 8'($urandom));
    enc_pos = enc_pos + 2'(dir);
    send_request(ACT_SAMPLE, level_for(enc_pos[1] ^ enc_pos[0]));
    send_request(ACT_SAMPLE, level_for(enc_pos[1]));
  endtask

  // Stops offering requests and waits until every result is back, so that
  // the block is idle. The first edge lets the checker see the last request.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes every register while the block is idle. The spare upper bits of
  // the narrow registers carry random junk that must be ignored, and an
  // unused index is written as well.
  task automatic configure(input logic cal, input logic en, input logic [7:0] val,
                           input logic [1:0] mode);
    settle();
    write_reg(CFG_CALIBRATE, {7'($urandom), cal});
    write_reg(CFG_COMPARE_ENABLE, {7'($urandom), en});
    write_reg(CFG_COMPARE_VALUE, val);
    write_reg(CFG_LED_MODE, {6'($urandom), mode});
    write_reg(CFG_UNUSED, 8'($urandom));
    cfg_valid_i <= 1'b0;
    cal_on = cal;
  endtask

  initial begin
    int unsigned r, n;
    logic [7:0]  lo, hi;
    bit          fwd;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With the reset threshold of 128, a sample of 128 reads
    // dark and 129 reads light; the extremes of the range come first.
    send_request(ACT_SAMPLE, 8'd0);
    send_request(ACT_SAMPLE, 8'd255);
    send_request(ACT_SAMPLE, 8'd128);
    send_request(ACT_SAMPLE, 8'd129);
    send_request(ACT_RESET_COUNT, 8'hFF);
    send_request(ACT_CLEAR_FLAG, 8'h00);
    send_request(ACT_SPARE, 8'($urandom));

    // Count wraps below zero onto the compare value of 255; the host then
    // clears the flag while the match still holds, so it comes back on the
    // following request.
    configure(1'b0, 1'b1, 8'hFF, LED_FLAG);
    send_request(ACT_RESET_COUNT, 8'($urandom));
    step_encoder(0);
    step_encoder(1);
    send_request(ACT_CLEAR_FLAG, 8'($urandom));
    step_encoder(0);
    step_encoder(-1);

    configure(1'b0, 1'b1, 8'h00, LED_COUNT);
    step_encoder(1);

    // Calibration on the two extremes, then the discarded sample that sets
    // the threshold, with the spare LED mode holding the indicator.
    configure(1'b1, 1'b0, 8'h80, LED_MODE_SPARE);
    send_request(ACT_SAMPLE, 8'd0);
    send_request(ACT_SAMPLE, 8'd255);
    configure(1'b0, 1'b0, 8'h80, LED_HOLD);
    send_request(ACT_SAMPLE, 8'($urandom));
    step_encoder(1);

    // Random part, in phases. Each phase may recalibrate on fresh dark and
    // light levels, picks new register settings and then mostly walks the
    // encoder, with count resets, flag clears and noise mixed in. Every
    // register write is preceded by a full drain of the results.
    for (int phase = 0; requests < RANDOM_END; phase++) begin
      quiet     = requests > QUIET_FROM;
      tx_gaps   = (phase % 3) != 2;
      rx_stalls = (phase % 3) != 1;
      if (phase % 2 == 0) begin
        lo = 8'($urandom_range(0, 60));
        hi = 8'($urandom_range(190, 255));
        n  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(8, 14);
        configure(1'b1, 1'($urandom), 8'($urandom), 2'($urandom));
        for (int k = 0; k < n; k++) begin
          send_request(ACT_SAMPLE, (k % 2) ? hi - 8'($urandom_range(0, 5))
                                           : lo + 8'($urandom_range(0, 5)));
        end
      end
      configure(1'b0, 1'($urandom),
                ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 6)),
                2'($urandom_range(0, 3)));
      fwd = (phase % 4) < 2;
      repeat (60) begin
        if (requests >= RANDOM_END) break;
        quiet = requests > QUIET_FROM;
        r = $urandom_range(0, 99);
        if (r < 80) begin
          n = $urandom_range(0, 9);
          step_encoder((n < 6) ? (fwd ? 1 : -1) : (n < 8) ? (fwd ? -1 : 1) : 0);
        end else if (r < 88) begin
          send_request(ACT_RESET_COUNT, 8'($urandom));
        end else if (r < 95) begin
          send_request(ACT_CLEAR_FLAG, 8'($urandom));
        end else if (r < 97) begin
          send_request(ACT_SPARE, 8'($urandom));
        end else begin
          send_request(ACT_SAMPLE, 8'($urandom));
        end
      end
    end

    // Drain, then allow for the pipeline before the verdict.
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/aqd_pkg.sv
design/aqd_cfg.sv
design/aqd_in_reg.sv
design/aqd_step.sv
design/analog_quadrature_decoder_core.sv
sim/aqd_checker.sv
sim/tb_top.sv
